FILE: sv/wrm_pkg.sv
`timescale 1ns / 1ps

package wrm_pkg;

    localparam int DEPTH_DEF        = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 10;
    localparam int TDATA_W    = 48;
    localparam int DECAY_W    = 16;
    localparam int WEIGHT_W   = 40;
    localparam int RECIP_W    = 32;
    localparam int DIGIT_W    = 16;
    localparam int OPB_W      = 32;
    localparam int ADDR_CMP_W = 17;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int NDIG_WEIGHT = (WEIGHT_W + DIGIT_W - 1) / DIGIT_W;
    localparam int DEN_W       = WEIGHT_W + 1;
    localparam int NUM_W       = RECIP_W + DECAY_W;

    localparam logic [CFG_ADDR_W-1:0] REG_DECAY         = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_UPDATE_ENABLE = 1'b1;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd32768;
    localparam logic [RECIP_W-1:0] RECIP_ONE   = 32'h8000_0000;

    typedef struct packed {
        logic load;
        logic step;
    } mul_ctrl_t;

endpackage

FILE: sv/weighted_running_mean.sv
`timescale 1ns / 1ps

// Bias-corrected exponential running mean over a vector of DEPTH elements. Each transaction
// carries one element sample with its index and returns that element's mean. After reset the
// block clears the mean store, one entry per cycle, before it takes any transaction. An element
// with updating enabled is read, takes NDIG 16-bit digit steps through the shared 16 x 32
// multiplier and is applied; a read-only or out-of-range element skips the multiplier. A
// transaction marked last with updating enabled then runs two multiplier passes, for the new
// weight and the reciprocal's denominator, then a one-bit-per-cycle 32-step divider. A decay
// write runs one multiplier pass for the denominator and the divider before the next
// transaction. Output stalls hold a transaction in its apply step.
module weighted_running_mean #(
    parameter int DEPTH        = wrm_pkg::DEPTH_DEF,
    parameter int SAMPLE_WIDTH = wrm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wrm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wrm_pkg::TDATA_W-1:0]    s_tdata,   // sample[31:0], element_index[41:32]
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wrm_pkg::TDATA_W-1:0]    m_tdata,   // mean[31:0], out_index[41:32]
    output logic                           m_tlast
);

    import wrm_pkg::*;

    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW        = SAMPLE_WIDTH;
    localparam int RW        = (SW > DATA_W) ? SW : DATA_W;
    localparam int NDIG_MEAN = (SW + DIGIT_W) / DIGIT_W;
    localparam int NDIG      = (NDIG_MEAN > NDIG_WEIGHT) ? NDIG_MEAN : NDIG_WEIGHT;
    localparam int OPA_W     = NDIG * DIGIT_W;
    localparam int ACC_W     = OPA_W + OPB_W;
    localparam int CNT_W     = $clog2(NDIG);

    localparam logic signed [RW-1:0] MAX_S = RW'(32'sh7FFF_FFFF);
    localparam logic signed [RW-1:0] MIN_S = RW'(32'sh8000_0000);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_APPLY,
        ST_WMUL,
        ST_WUPD,
        ST_DIV
    } state_t;

    state_t state_reg;

    logic [DECAY_W-1:0]  decay_reg;
    logic                upd_en_reg;
    logic                pend_reg;
    logic                pend_clr;

    logic [AW-1:0]       clr_cnt_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                wphase_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [RECIP_W-1:0]  recip_reg;

    logic signed [SW-1:0] x_reg;
    logic signed [SW-1:0] m_old_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [AW-1:0]        addr_reg;
    logic                 last_reg;
    logic                 in_range_reg;
    logic                 upd_reg;
    logic                 neg_reg;

    logic                 m_valid_reg;
    logic [TDATA_W-1:0]   m_tdata_reg;
    logic                 m_last_reg;

    logic [IDX_W-1:0]      s_idx;
    logic [ADDR_CMP_W-1:0] s_idx_ext;
    logic [RW-1:0]         s_raw_ext;
    logic signed [SW-1:0]  s_x;
    logic                  s_in_range;
    logic [AW-1:0]         s_addr;

    logic                 store_we;
    logic [AW-1:0]        store_waddr;
    logic [SW-1:0]        store_wdata;
    logic [SW-1:0]        store_rdata;

    logic signed [SW:0]   m_rd;
    logic signed [SW:0]   diff;
    logic [SW:0]          mag;

    mul_ctrl_t            mul_ctrl;
    logic [OPA_W-1:0]     mul_opa;
    logic [OPB_W-1:0]     mul_opb;
    logic [ACC_W-1:0]     acc;
    logic [ACC_W-1:0]     acc_m;
    logic [ACC_W-1:0]     acc_w;
    logic [SW:0]          r_mag;
    logic signed [SW:0]   m_sum;
    logic signed [SW-1:0] m_res;
    logic signed [RW-1:0] m_wide;
    logic [DATA_W-1:0]    mean_sat;

    logic [WEIGHT_W-1:0]  wa;
    logic [DEN_W-1:0]     w_sum;
    logic [WEIGHT_W-1:0]  w_sat;

    logic                 do_upd;
    logic                 out_free;
    logic                 div_start;
    logic                 div_done;
    logic [RECIP_W-1:0]   div_quot;

    assign s_idx      = s_tdata[DATA_W +: IDX_W];
    assign s_idx_ext  = ADDR_CMP_W'(s_idx);
    assign s_raw_ext  = RW'(s_tdata[DATA_W-1:0]);
    assign s_x        = $signed(s_raw_ext[SW-1:0]);
    assign s_in_range = s_idx_ext < ADDR_CMP_W'(DEPTH);
    assign s_addr     = s_idx_ext[AW-1:0];

    assign do_upd   = upd_reg && in_range_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !pend_reg;
    assign pend_clr = (state_reg == ST_IDLE) && pend_reg;

    assign m_rd = in_range_reg ? (SW + 1)'($signed(store_rdata)) : '0;
    assign diff = (SW + 1)'(x_reg) - m_rd;
    assign mag  = diff[SW] ? (SW + 1)'(-diff) : diff;

    // The product holds |x - m| * reciprocal in Q.31; round half up on the magnitude.
    assign acc_m = acc + (ACC_W'(1) << (RECIP_W - 2));
    assign r_mag = acc_m[RECIP_W-1 +: SW + 1];
    assign m_sum = neg_reg ? (SW + 1)'(m_old_reg) - $signed(r_mag)
                           : (SW + 1)'(m_old_reg) + $signed(r_mag);
    assign m_res = do_upd ? m_sum[SW-1:0] : m_old_reg;

    assign m_wide   = RW'(m_res);
    assign mean_sat = (m_wide > MAX_S) ? DATA_W'(MAX_S) :
                      (m_wide < MIN_S) ? DATA_W'(MIN_S) : m_wide[DATA_W-1:0];

    assign acc_w = acc + (ACC_W'(1) << (DECAY_W - 1));
    assign wa    = acc_w[DECAY_W +: WEIGHT_W];
    assign w_sum = DEN_W'(wa) + (DEN_W'(1) << DECAY_W);
    assign w_sat = w_sum[WEIGHT_W] ? '1 : w_sum[WEIGHT_W-1:0];

    assign div_start = (state_reg == ST_WUPD) && wphase_reg;

    assign store_we    = (state_reg == ST_CLEAR) ||
                         ((state_reg == ST_APPLY) && out_free && do_upd);
    assign store_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign store_wdata = (state_reg == ST_CLEAR) ? '0 : m_res;

    always_comb begin
        mul_ctrl      = '0;
        mul_opa       = OPA_W'(weight_reg);
        mul_opb       = OPB_W'(decay_reg);
        mul_ctrl.step = (state_reg == ST_MUL) || (state_reg == ST_WMUL);
        unique case (state_reg)
            ST_IDLE: begin
                mul_ctrl.load = pend_reg;
            end
            ST_READ: begin
                mul_ctrl.load = do_upd;
                mul_opa       = OPA_W'(mag);
                mul_opb       = recip_reg;
            end
            ST_APPLY: begin
                mul_ctrl.load = out_free && upd_reg && last_reg;
            end
            ST_WUPD: begin
                mul_ctrl.load = !wphase_reg;
                mul_opa       = OPA_W'(w_sat);
            end
            default: begin
                mul_ctrl.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg  <= DECAY_RESET;
            upd_en_reg <= 1'b1;
            pend_reg   <= 1'b0;
        end else begin
            if (pend_clr) begin
                pend_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_DECAY: begin
                        decay_reg <= cfg_wdata[DECAY_W-1:0];
                        pend_reg  <= 1'b1;
                    end
                    REG_UPDATE_ENABLE: begin
                        upd_en_reg <= cfg_wdata[0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            weight_reg  <= '0;
            recip_reg   <= RECIP_ONE;
            wphase_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (pend_reg) begin
                        wphase_reg <= 1'b1;
                        cnt_reg    <= '0;
                        state_reg  <= ST_WMUL;
                    end else if (s_tvalid) begin
                        x_reg        <= s_x;
                        idx_reg      <= s_idx;
                        addr_reg     <= s_addr;
                        last_reg     <= s_tlast;
                        in_range_reg <= s_in_range;
                        upd_reg      <= upd_en_reg;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    m_old_reg <= m_rd[SW-1:0];
                    neg_reg   <= diff[SW];
                    cnt_reg   <= '0;
                    state_reg <= do_upd ? ST_MUL : ST_APPLY;
                end
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NDIG - 1)) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_tdata_reg <= TDATA_W'({idx_reg, mean_sat});
                        m_last_reg  <= last_reg;
                        if (upd_reg && last_reg) begin
                            wphase_reg <= 1'b0;
                            cnt_reg    <= '0;
                            state_reg  <= ST_WMUL;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_WMUL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NDIG - 1)) begin
                        state_reg <= ST_WUPD;
                    end
                end
                ST_WUPD: begin
                    if (!wphase_reg) begin
                        weight_reg <= w_sat;
                        wphase_reg <= 1'b1;
                        cnt_reg    <= '0;
                        state_reg  <= ST_WMUL;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        recip_reg <= div_quot;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_last_reg;

    wrm_mean_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SW)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (s_addr),
        .rdata (store_rdata)
    );

    wrm_mul_unit #(
        .OPA_W (OPA_W)
    ) u_mul (
        .aclk (aclk),
        .ctrl (mul_ctrl),
        .opa  (mul_opa),
        .opb  (mul_opb),
        .acc  (acc)
    );

    wrm_recip_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den     (w_sum),
        .done    (div_done),
        .quot    (div_quot)
    );

    a_recip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        recip_reg <= RECIP_ONE)
        else $error("Pass reciprocal exceeds one.");

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_READ)
        else $error("Accepted transaction did not start a store read.");

    a_weight_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(weight_reg) |-> $past(state_reg) == ST_WUPD)
        else $error("History weight changed outside the weight update.");

endmodule

FILE: sv/wrm_mean_store.sv
`timescale 1ns / 1ps

module wrm_mean_store #(
    parameter int DEPTH = wrm_pkg::DEPTH_DEF,
    parameter int AW    = 10,
    parameter int DW    = wrm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/wrm_mul_unit.sv
`timescale 1ns / 1ps

module wrm_mul_unit #(
    parameter int OPA_W = 48
) (
    input  logic                            aclk,
    input  wrm_pkg::mul_ctrl_t              ctrl,
    input  logic [OPA_W-1:0]                opa,
    input  logic [wrm_pkg::OPB_W-1:0]       opb,
    output logic [OPA_W+wrm_pkg::OPB_W-1:0] acc
);

    import wrm_pkg::*;

    localparam int ACC_W  = OPA_W + OPB_W;
    localparam int PROD_W = DIGIT_W + OPB_W;

    logic [OPA_W-1:0]   opa_reg;
    logic [OPB_W-1:0]   opb_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [DIGIT_W-1:0] digit;
    logic [PROD_W-1:0]  prod;

    // Digits are consumed most significant first, so the sum is built in Horner form.
    assign digit = opa_reg[OPA_W-1 -: DIGIT_W];
    assign prod  = PROD_W'(digit) * PROD_W'(opb_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            opa_reg <= opa;
            opb_reg <= opb;
            acc_reg <= '0;
        end else if (ctrl.step) begin
            opa_reg <= opa_reg << DIGIT_W;
            acc_reg <= (acc_reg << DIGIT_W) + ACC_W'(prod);
        end
    end

    assign acc = acc_reg;

endmodule

FILE: sv/wrm_recip_div.sv
`timescale 1ns / 1ps

module wrm_recip_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [wrm_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [wrm_pkg::RECIP_W-1:0] quot
);

    import wrm_pkg::*;

    localparam int CNT_W = $clog2(RECIP_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [RECIP_W-1:0] num_reg;
    logic [RECIP_W-1:0] q_reg;
    logic [NUM_W-1:0]   num;
    logic [DEN_W:0]     trial;
    logic               fits;

    // Rounded quotient: the dividend carries half the divisor.
    assign num   = (NUM_W'(1) << (NUM_W - 1)) + NUM_W'(den >> 1);
    assign trial = {rem_reg, num_reg[RECIP_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                den_reg  <= den;
                rem_reg  <= DEN_W'(num[NUM_W-1:RECIP_W]);
                num_reg  <= num[RECIP_W-1:0];
                q_reg    <= '0;
            end else if (busy_reg) begin
                num_reg <= num_reg << 1;
                q_reg   <= {q_reg[RECIP_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (fits) begin
                    rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                end else begin
                    rem_reg <= trial[DEN_W-1:0];
                end
                if (cnt_reg == CNT_W'(RECIP_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
